// ===== rtl/pidffaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidffaw_pkg
// Shared types and constants for the PID controller with feedforward and
// clamping anti-windup.
// ----------------------------------------------------------------------------
package pidffaw_pkg;

	localparam int DATA_W         = 32;
	localparam int DT_W           = 31;
	localparam int FRAC_BITS      = 16;
	localparam int INTEGRAL_WIDTH = 48;

	// feedforward gate: |setpoint| above 0.01 in raw fixed point
	localparam int FF_THRESHOLD = (1 << FRAC_BITS) / 100;

	// exact product width used for rounding
	localparam int XW = 2 * DATA_W + 2;
	// error * sample_interval after the fraction shift
	localparam int TERM_W    = 2 * DATA_W - 1 - FRAC_BITS;
	localparam int TERM_LO_W = (TERM_W + 1) / 2;
	// integral plus one step, before saturation
	localparam int ACC_SUM_W = ((INTEGRAL_WIDTH > TERM_W) ? INTEGRAL_WIDTH : TERM_W) + 1;
	// exact ki * integral
	localparam int PROD_W   = DATA_W + ACC_SUM_W;
	localparam int INT_LO_W = (INTEGRAL_WIDTH + 1) / 2;
	// integral term magnitude limit is 2^TERM_LIMIT_LOG2
	localparam int TERM_LIMIT_LOG2 = 60;
	localparam int ITERM_W         = TERM_LIMIT_LOG2 + 2;
	localparam int SUM_W           = 64;

	typedef enum logic [2:0] {
		REG_KP      = 3'd0,
		REG_KI      = 3'd1,
		REG_KD      = 3'd2,
		REG_KFF     = 3'd3,
		REG_OUT_MIN = 3'd4,
		REG_OUT_MAX = 3'd5,
		REG_DT      = 3'd6
	} pidffaw_reg_t;

	typedef enum logic [1:0] {
		RC_IDLE,
		RC_MUL,
		RC_SUM,
		RC_ROUND
	} pidffaw_rc_state_t;

	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] setpoint;
		logic signed [DATA_W-1:0] measured;
	} pidffaw_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     clamped;
	} pidffaw_rsp_t;

endpackage

// ===== rtl/pid_feedforward_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_feedforward_antiwindup
// Q16.16 PID step with setpoint feedforward, output clamp and conditional
// integration.
// ----------------------------------------------------------------------------
// A result is valid once its command beat has passed the pipeline stages and
// the result register. Throughput: one command beat per cycle, unless the
// result beat is held or a write to ki_gain stalls commands while ki*integral
// is rebuilt; the integral loop closes in the last stage through a kept exact
// ki*integral product and its rounded term. Reset clears the pipeline, the
// integral and the last error, and loads the register defaults.
module pid_feedforward_antiwindup (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  pidffaw_pkg::pidffaw_cmd_t   cmd,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output pidffaw_pkg::pidffaw_rsp_t   rsp,
	input  logic                        cfg_wr_en,
	input  logic [2:0]                  cfg_index,
	input  logic [pidffaw_pkg::DATA_W-1:0] cfg_wdata
);

	localparam int DW  = pidffaw_pkg::DATA_W;
	localparam int FB  = pidffaw_pkg::FRAC_BITS;
	localparam int IW  = pidffaw_pkg::INTEGRAL_WIDTH;
	localparam int XW  = pidffaw_pkg::XW;
	localparam int TW  = pidffaw_pkg::TERM_W;
	localparam int TL  = pidffaw_pkg::TERM_LO_W;
	localparam int AW  = pidffaw_pkg::ACC_SUM_W;
	localparam int PW  = pidffaw_pkg::PROD_W;
	localparam int IL  = pidffaw_pkg::INT_LO_W;
	localparam int ITW = pidffaw_pkg::ITERM_W;
	localparam int SW  = pidffaw_pkg::SUM_W;

	localparam logic signed [DW-1:0] FF_POS = DW'(pidffaw_pkg::FF_THRESHOLD);
	localparam logic signed [DW-1:0] FF_NEG = -FF_POS;
	localparam logic signed [DW-1:0] E_MAX  = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] E_MIN  = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [XW-1:0] BIAS_X = XW'((65'd1 << FB) - 65'd1);
	localparam logic signed [XW-1:0] ZERO_X = '0;
	localparam logic signed [PW-1:0] BIAS_P = PW'((65'd1 << FB) - 65'd1);
	localparam logic signed [PW-1:0] ZERO_P = '0;
	localparam logic signed [PW-1:0] I_LIM  = PW'(1) <<< pidffaw_pkg::TERM_LIMIT_LOG2;
	localparam logic signed [AW-1:0] IMAX_A = AW'({1'b0, {(IW-1){1'b1}}});
	localparam logic signed [AW-1:0] IMIN_A = -IMAX_A - AW'(1);
	localparam logic signed [IW-1:0] IMAX   = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0] IMIN   = {1'b1, {(IW-1){1'b0}}};

	// product >> FB, rounded toward zero
	function automatic logic signed [XW-1:0] rnd_x(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] b;
		b = x[XW-1] ? BIAS_X : ZERO_X;
		return (x + b) >>> FB;
	endfunction

	// ki*integral >> FB toward zero, magnitude limited
	function automatic logic signed [ITW-1:0] rnd_i(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] b;
		logic signed [PW-1:0] y;
		b = x[PW-1] ? BIAS_P : ZERO_P;
		y = (x + b) >>> FB;
		if (y > I_LIM)
			return ITW'(I_LIM);
		else if (y < -I_LIM)
			return ITW'(-I_LIM);
		else
			return y[ITW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// configuration
	logic signed [DW-1:0]   kp_q, ki_q, kd_q, kff_q, out_min_q, out_max_q;
	logic        [pidffaw_pkg::DT_W-1:0] dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= 32'sd655360;
			ki_q      <= 32'sd655360;
			kd_q      <= 32'sd0;
			kff_q     <= 32'sd286130;
			out_min_q <= -32'sd6553600;
			out_max_q <= 32'sd6553600;
			dt_q      <= 31'd1311;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pidffaw_pkg::REG_KP:      kp_q      <= $signed(cfg_wdata);
				pidffaw_pkg::REG_KI:      ki_q      <= $signed(cfg_wdata);
				pidffaw_pkg::REG_KD:      kd_q      <= $signed(cfg_wdata);
				pidffaw_pkg::REG_KFF:     kff_q     <= $signed(cfg_wdata);
				pidffaw_pkg::REG_OUT_MIN: out_min_q <= $signed(cfg_wdata);
				pidffaw_pkg::REG_OUT_MAX: out_max_q <= $signed(cfg_wdata);
				pidffaw_pkg::REG_DT:      dt_q      <= cfg_wdata[pidffaw_pkg::DT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// flow control: whole pipeline moves unless the result beat is held
	pidffaw_pkg::pidffaw_rc_state_t rc_state_q, rc_state_d;
	logic adv, rc_busy, take;
	logic rsp_valid_q;
	pidffaw_pkg::pidffaw_rsp_t rsp_q;

	assign adv       = !(rsp_valid_q && rsp_stall);
	assign rc_busy   = (rc_state_q != pidffaw_pkg::RC_IDLE);
	assign cmd_stall = !adv || rc_busy;
	assign take      = cmd_valid && !cmd_stall;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: input register
	logic                 act_s1;
	logic signed [DW-1:0] sp_s1, ms_s1;

	always_ff @(posedge clk) begin
		if (adv && take) begin
			act_s1 <= cmd.action;
			sp_s1  <= cmd.setpoint;
			ms_s1  <= cmd.measured;
		end
	end

	// error with saturation, derivative difference, feedforward gate
	logic signed [DW:0]   err_w;
	logic signed [DW-1:0] err_c;
	logic signed [DW-1:0] prev_err_q;

	always_comb begin
		err_w = $signed({sp_s1[DW-1], sp_s1}) - $signed({ms_s1[DW-1], ms_s1});
		if (err_w[DW] != err_w[DW-1])
			err_c = err_w[DW] ? E_MIN : E_MAX;
		else
			err_c = err_w[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prev_err_q <= '0;
		else if (adv && v_s1)
			prev_err_q <= act_s1 ? '0 : err_c;
	end

	// stage 2
	logic                 act_s2, ff_en_s2;
	logic signed [DW-1:0] err_s2, sp_s2;
	logic signed [DW:0]   diff_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2   <= act_s1;
			err_s2   <= err_c;
			sp_s2    <= sp_s1;
			diff_s2  <= $signed({err_c[DW-1], err_c}) -
			            $signed({prev_err_q[DW-1], prev_err_q});
			ff_en_s2 <= (sp_s1 > FF_POS) || (sp_s1 < FF_NEG);
		end
	end

	// stage 3: exact products
	logic                   act_s3;
	logic signed [2*DW-1:0] ff_prod_s3, p_prod_s3, t_prod_s3;
	logic signed [2*DW:0]   d_prod_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3     <= act_s2;
			if (ff_en_s2)
				ff_prod_s3 <= sp_s2 * kff_q;
			else
				ff_prod_s3 <= '0;
			p_prod_s3  <= err_s2 * kp_q;
			d_prod_s3  <= diff_s2 * kd_q;
			t_prod_s3  <= err_s2 * $signed({1'b0, dt_q});
		end
	end

	// stage 4: fraction shift toward zero
	logic                 act_s4;
	logic signed [SW-1:0] ff_s4, p_s4, d_s4;
	logic signed [TW-1:0] t_s4;
	logic signed [XW-1:0] ff_r, p_r, d_r, t_r;

	always_comb begin
		ff_r = rnd_x(XW'(ff_prod_s3));
		p_r  = rnd_x(XW'(p_prod_s3));
		d_r  = rnd_x(XW'(d_prod_s3));
		t_r  = rnd_x(XW'(t_prod_s3));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4 <= act_s3;
			ff_s4  <= SW'(ff_r);
			p_s4   <= SW'(p_r);
			d_s4   <= SW'(d_r);
			t_s4   <= t_r[TW-1:0];
		end
	end

	// stage 5: state-free part of the sum, ki*t split in halves
	logic                       act_s5;
	logic signed [SW-1:0]       base_s5;
	logic signed [TW-1:0]       t_s5;
	logic signed [DW+TL:0]      kt_lo_s5;
	logic signed [DW+TW-TL-1:0] kt_hi_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s5   <= act_s4;
			base_s5  <= ff_s4 + p_s4 + d_s4;
			t_s5     <= t_s4;
			kt_lo_s5 <= ki_q * $signed({1'b0, t_s4[TL-1:0]});
			kt_hi_s5 <= ki_q * $signed(t_s4[TW-1:TL]);
		end
	end

	// stage 6
	logic                 act_s6;
	logic signed [SW-1:0] base_s6;
	logic signed [TW-1:0] t_s6;
	logic signed [PW-1:0] kt_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s6  <= act_s5;
			base_s6 <= base_s5;
			t_s6    <= t_s5;
			kt_s6   <= (PW'(kt_hi_s5) <<< TL) + PW'(kt_lo_s5);
		end
	end

	// ------------------------------------------------------------------
	// loop stage: clamp decision and state update
	logic signed [IW-1:0]  integ_q;
	logic signed [PW-1:0]  prod_q;   // exact ki * integ_q
	logic signed [ITW-1:0] i_q;      // rounded, limited integral term

	logic signed [SW-1:0]  sum_c;
	logic                  hi_c, lo_c, clamp_c;
	logic signed [DW-1:0]  drive_c;
	logic signed [AW-1:0]  acc_c;
	logic signed [PW-1:0]  ki_imax, ki_imin;
	logic signed [IW-1:0]  integ_upd;
	logic signed [PW-1:0]  prod_upd;
	logic signed [ITW-1:0] i_upd;

	always_comb begin
		sum_c   = SW'(base_s6) + SW'(i_q);
		hi_c    = sum_c > SW'(out_max_q);
		lo_c    = sum_c < SW'(out_min_q);
		clamp_c = hi_c || lo_c;
		if (hi_c)
			drive_c = out_max_q;
		else if (lo_c)
			drive_c = out_min_q;
		else
			drive_c = sum_c[DW-1:0];

		ki_imax = (PW'(ki_q) <<< (IW - 1)) - PW'(ki_q);
		ki_imin = -(PW'(ki_q) <<< (IW - 1));
		acc_c   = AW'(integ_q) + AW'(t_s6);
		if (acc_c > IMAX_A) begin
			integ_upd = IMAX;
			prod_upd  = ki_imax;
		end else if (acc_c < IMIN_A) begin
			integ_upd = IMIN;
			prod_upd  = ki_imin;
		end else begin
			integ_upd = acc_c[IW-1:0];
			prod_upd  = prod_q + kt_s6;
		end
		i_upd = rnd_i(prod_upd);
	end

	// ki*integral rebuild after a ki write
	logic signed [DW+IL:0]    rc_lo_q;
	logic signed [DW+IW-IL-1:0] rc_hi_q;

	always_ff @(posedge clk) begin
		if (rc_state_q == pidffaw_pkg::RC_MUL) begin
			rc_lo_q <= ki_q * $signed({1'b0, integ_q[IL-1:0]});
			rc_hi_q <= ki_q * $signed(integ_q[IW-1:IL]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rc_state_q <= pidffaw_pkg::RC_IDLE;
		else
			rc_state_q <= rc_state_d;
	end

	always_comb begin
		rc_state_d = rc_state_q;
		unique case (rc_state_q)
			pidffaw_pkg::RC_IDLE:  rc_state_d = pidffaw_pkg::RC_IDLE;
			pidffaw_pkg::RC_MUL:   rc_state_d = pidffaw_pkg::RC_SUM;
			pidffaw_pkg::RC_SUM:   rc_state_d = pidffaw_pkg::RC_ROUND;
			pidffaw_pkg::RC_ROUND: rc_state_d = pidffaw_pkg::RC_IDLE;
			default:               rc_state_d = pidffaw_pkg::RC_IDLE;
		endcase
		if (cfg_wr_en && cfg_index == pidffaw_pkg::REG_KI)
			rc_state_d = pidffaw_pkg::RC_MUL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prod_q  <= '0;
			i_q     <= '0;
		end else if (adv && v_s6) begin
			if (act_s6) begin
				integ_q <= '0;
				prod_q  <= '0;
				i_q     <= '0;
			end else if (!clamp_c) begin
				integ_q <= integ_upd;
				prod_q  <= prod_upd;
				i_q     <= i_upd;
			end
		end else if (rc_state_q == pidffaw_pkg::RC_SUM) begin
			prod_q <= (PW'(rc_hi_q) <<< IL) + PW'(rc_lo_q);
		end else if (rc_state_q == pidffaw_pkg::RC_ROUND) begin
			i_q <= rnd_i(prod_q);
		end
	end

	// ------------------------------------------------------------------
	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (adv)
			rsp_valid_q <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s6) begin
			rsp_q.drive   <= act_s6 ? '0 : drive_c;
			rsp_q.clamped <= act_s6 ? 1'b0 : clamp_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// checks
	a_rc_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rc_busy |-> cmd_stall)
		else $error("command taken during ki*integral rebuild");

	a_clear_on_reset_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s6 && act_s6) |=> (integ_q == '0 && prod_q == '0 && i_q == '0))
		else $error("state not cleared by reset beat");

	a_hold_when_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s6 && !act_s6 && clamp_c) |=> ($stable(integ_q) && $stable(i_q)))
		else $error("integral moved on a clamped step");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.clamped) |-> (rsp.drive == out_max_q || rsp.drive == out_min_q))
		else $error("clamped drive is not a limit");

endmodule

// ===== tb/sv/tb_pid_feedforward_antiwindup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_feedforward_antiwindup
// Self-checking bench for the Q16.16 PID step with feedforward and clamp
// anti-windup. Command beats go in through valid/stall with random gaps, and
// response beats come back under random stall. A predictor in the bench keeps
// its own gains, limits, last error and integral, and each response beat is
// checked field by field against the oldest predicted drive. Directed steps
// cover the feedforward gate, error and integral saturation, extreme gains and
// swapped limits. A long random run follows under several register settings.
// ----------------------------------------------------------------------------
module tb_pid_feedforward_antiwindup;

	localparam int DATA_W          = pidffaw_pkg::DATA_W;
	localparam int DT_W            = pidffaw_pkg::DT_W;
	localparam int FRAC_BITS       = pidffaw_pkg::FRAC_BITS;
	localparam int INTEGRAL_WIDTH  = pidffaw_pkg::INTEGRAL_WIDTH;
	localparam int TERM_LIMIT_LOG2 = pidffaw_pkg::TERM_LIMIT_LOG2;
	localparam int FF_THRESHOLD    = pidffaw_pkg::FF_THRESHOLD;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] ONE   = 32'sd65536;
	localparam longint ERR_MAX  = longint'(Q_MAX);
	localparam longint ERR_MIN  = longint'(Q_MIN);
	localparam longint IACC_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
	localparam longint IACC_MIN = -IACC_MAX - 1;
	localparam logic [63:0] TERM_LIMIT = 64'd1 << TERM_LIMIT_LOG2;

	logic                       clk;
	logic                       arst_n;
	logic                       cmd_valid;
	logic                       cmd_stall;
	pidffaw_pkg::pidffaw_cmd_t  cmd;
	logic                       rsp_valid;
	logic                       rsp_stall;
	pidffaw_pkg::pidffaw_rsp_t  rsp;
	logic                       cfg_wr_en;
	logic [2:0]                 cfg_index;
	logic [DATA_W-1:0]          cfg_wdata;

	// predictor copy of the registers and loop state
	logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, kff_q, drive_lo, drive_hi;
	logic [DT_W-1:0]          dt_q;
	logic signed [DATA_W-1:0] err_last;
	longint                   integ;

	pidffaw_pkg::pidffaw_rsp_t drive_q[$];
	bit           idle_on;
	int           fails = 0;
	int           cycles = 0;

	pid_feedforward_antiwindup i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_pid_feedforward_antiwindup NOT OK");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_stall <= idle_on && ($urandom_range(99) < 12);
	end

	always @(posedge clk) begin : check_beat
		pidffaw_pkg::pidffaw_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (drive_q.size() == 0) begin
				$error("response beat with nothing expected: drive %0d", rsp.drive);
				fails++;
			end else begin
				want = drive_q.pop_front();
				if (rsp.drive !== want.drive) begin
					$error("drive: expected %0d, got %0d", want.drive, rsp.drive);
					fails++;
				end
				if (rsp.clamped !== want.clamped) begin
					$error("clamped: expected %0b, got %0b", want.clamped, rsp.clamped);
					fails++;
				end
			end
		end
	end

	// (a*b) >> FRAC_BITS toward zero, magnitude held at 2^60
	function automatic longint qmul(input longint a, input longint b);
		logic [127:0] prod;
		logic [63:0]  ua, ub;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		prod = ua * ub;
		prod = prod >> FRAC_BITS;
		if (prod > TERM_LIMIT)
			prod = TERM_LIMIT;
		return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic pidffaw_pkg::pidffaw_rsp_t pid_step(input pidffaw_pkg::pidffaw_cmd_t c);
		pidffaw_pkg::pidffaw_rsp_t r;
		longint       sp, ms, e, ff, pt, it, dterm, sum;
		r.drive   = '0;
		r.clamped = 1'b0;
		if (c.action) begin
			err_last = '0;
			integ    = 0;
			return r;
		end
		sp = $signed(c.setpoint);
		ms = $signed(c.measured);
		e  = sp - ms;
		if (e > ERR_MAX)
			e = ERR_MAX;
		if (e < ERR_MIN)
			e = ERR_MIN;
		ff    = (((sp < 0) ? -sp : sp) > FF_THRESHOLD) ? qmul(sp, kff_q) : 0;
		pt    = qmul(e, kp_q);
		it    = qmul(ki_q, integ);
		dterm = qmul(e - err_last, kd_q);
		sum   = ff + pt + it + dterm;
		// upper limit is tested first, which decides swapped limits
		if (sum > drive_hi) begin
			r.drive   = drive_hi;
			r.clamped = 1'b1;
		end else if (sum < drive_lo) begin
			r.drive   = drive_lo;
			r.clamped = 1'b1;
		end else begin
			r.drive = sum[DATA_W-1:0];
			integ   = integ + qmul(e, dt_q);
			if (integ > IACC_MAX)
				integ = IACC_MAX;
			if (integ < IACC_MIN)
				integ = IACC_MIN;
		end
		err_last = e[DATA_W-1:0];
		return r;
	endfunction

	task automatic send_cmd(input logic act, input logic signed [DATA_W-1:0] sp,
			input logic signed [DATA_W-1:0] ms);
		pidffaw_pkg::pidffaw_cmd_t c;
		c.action   = act;
		c.setpoint = sp;
		c.measured = ms;
		while (idle_on && $urandom_range(99) < 12) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		drive_q.push_back(pid_step(c));
		@(negedge clk);
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (drive_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input pidffaw_pkg::pidffaw_reg_t idx,
			input logic [DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			pidffaw_pkg::REG_KP:      kp_q     = val;
			pidffaw_pkg::REG_KI:      ki_q     = val;
			pidffaw_pkg::REG_KD:      kd_q     = val;
			pidffaw_pkg::REG_KFF:     kff_q    = val;
			pidffaw_pkg::REG_OUT_MIN: drive_lo = val;
			pidffaw_pkg::REG_OUT_MAX: drive_hi = val;
			pidffaw_pkg::REG_DT:      dt_q     = val[DT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// caller makes sure the block is idle
	task automatic load_config(input logic signed [DATA_W-1:0] kp, ki, kd, kff, lo, hi,
			input logic [DT_W-1:0] dt);
		write_reg(pidffaw_pkg::REG_KP, kp);
		write_reg(pidffaw_pkg::REG_KI, ki);
		write_reg(pidffaw_pkg::REG_KD, kd);
		write_reg(pidffaw_pkg::REG_KFF, kff);
		write_reg(pidffaw_pkg::REG_OUT_MIN, lo);
		write_reg(pidffaw_pkg::REG_OUT_MAX, hi);
		write_reg(pidffaw_pkg::REG_DT, {1'b0, dt});
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [DATA_W-1:0] rand_q();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(15))
			0, 1: v = $urandom;
			2: begin
				case ($urandom_range(6))
					0: v = Q_MIN;
					1: v = Q_MAX;
					2: v = 0;
					3: v = -1;
					4: v = FF_THRESHOLD;
					5: v = -FF_THRESHOLD - 1;
					default: v = ONE;
				endcase
			end
			default: begin
				v = $urandom_range(2097152);
				v = v - 32'sd1048576;
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_gain();
		logic signed [DATA_W-1:0] g;
		case ($urandom_range(7))
			0: g = $urandom;
			1: g = $urandom_range(1) ? Q_MAX : Q_MIN;
			default: begin
				g = $urandom_range(2097152);
				g = g - 32'sd1048576;
			end
		endcase
		return g;
	endfunction

	task automatic random_config();
		logic signed [DATA_W-1:0] lo, hi, t;
		logic [DT_W-1:0]          dt;
		lo = $urandom_range(16777216);
		lo = -lo;
		hi = $urandom_range(16777216);
		case ($urandom_range(7))
			0: begin
				t  = lo;
				lo = hi;
				hi = t;
			end
			1: begin
				lo = Q_MIN;
				hi = Q_MAX;
			end
			2: begin
				lo = $urandom;
				hi = $urandom;
			end
			default: ;
		endcase
		case ($urandom_range(7))
			0: dt = '0;
			1: dt = '1;
			2: dt = DT_W'($urandom);
			default: dt = DT_W'($urandom_range(65536));
		endcase
		load_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(), lo, hi, dt);
	endtask

	// register defaults from reset: feedforward gate edges and error saturation
	task automatic test_default_gains();
		send_cmd(1'b1, Q_MAX, Q_MIN);
		send_cmd(1'b0, 0, 0);
		send_cmd(1'b0, ONE, ONE / 2);
		send_cmd(1'b0, ONE, ONE / 2);
		send_cmd(1'b0, FF_THRESHOLD, 0);
		send_cmd(1'b0, FF_THRESHOLD + 1, 0);
		send_cmd(1'b0, -FF_THRESHOLD, 0);
		send_cmd(1'b0, -FF_THRESHOLD - 1, 0);
		send_cmd(1'b0, Q_MAX, Q_MIN);
		send_cmd(1'b0, Q_MIN, Q_MAX);
	endtask

	// ki of one LSB so the integral term tracks the integral; it saturates
	// upward, lands exactly on out_max, then saturates downward
	task automatic test_integral_saturation();
		drain_results();
		load_config(0, 1, 0, 0, Q_MIN, Q_MAX, '1);
		send_cmd(1'b1, 0, 0);
		repeat (3) send_cmd(1'b0, Q_MAX, Q_MIN);
		send_cmd(1'b0, 0, 0);
		repeat (5) send_cmd(1'b0, Q_MIN, Q_MAX);
	endtask

	// integral is at its negative limit here, so ki*integral hits the term cap
	task automatic test_extreme_gains();
		drain_results();
		load_config(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '1);
		send_cmd(1'b0, 0, 0);
		send_cmd(1'b0, Q_MAX, Q_MIN);
		send_cmd(1'b0, Q_MIN, Q_MAX);
		send_cmd(1'b0, ONE, 0);
	endtask

	task automatic test_swapped_limits();
		drain_results();
		load_config(655360, 655360, 0, 286130, 6553600, -6553600, 1311);
		send_cmd(1'b1, 0, 0);
		send_cmd(1'b0, 0, 0);
		send_cmd(1'b0, 0, ONE * 5);
		send_cmd(1'b0, ONE * 5, 0);
	endtask

	task automatic test_random_steps(input int chunks, input int per_chunk);
		logic                     act;
		logic signed [DATA_W-1:0] sp, ms;
		for (int k = 0; k < chunks; k++) begin
			drain_results();
			random_config();
			for (int n = 0; n < per_chunk; n++) begin
				act = ($urandom_range(99) < 4);
				sp  = rand_q();
				// mostly track the setpoint closely so the loop is less often clamped
				if ($urandom_range(3) == 0) begin
					ms = rand_q();
				end else begin
					ms = $urandom_range(131072);
					ms = sp - ONE + ms;
				end
				send_cmd(act, sp, ms);
				if ($urandom_range(99) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_wr_en = 1'b0;
		cfg_index = pidffaw_pkg::REG_KP;
		cfg_wdata = '0;
		idle_on   = 1'b1;
		kp_q      = 655360;
		ki_q      = 655360;
		kd_q      = 0;
		kff_q     = 286130;
		drive_lo  = -6553600;
		drive_hi  = 6553600;
		dt_q      = 1311;
		err_last  = '0;
		integ     = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_gains();
		test_integral_saturation();
		test_extreme_gains();
		test_swapped_limits();
		test_random_steps(4, 250);
		idle_on = 1'b0;
		test_random_steps(1, 300);
		idle_on = 1'b1;
		test_random_steps(1, 200);

		drain_results();
		repeat (20) @(negedge clk);
		if (fails == 0 && drive_q.size() == 0)
			$display("tb_pid_feedforward_antiwindup OK");
		else
			$display("tb_pid_feedforward_antiwindup NOT OK");
		$finish;
	end

endmodule
